// ===== design/lbc_pkg.sv =====
// ----------------------------------------------------------------------------
// lbc_pkg
// Shared types, constants and helpers for the LED blink controller.
// ----------------------------------------------------------------------------
package lbc_pkg;

   localparam int NUM_LEDS  = 8;
   localparam int LED_IDX_W = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;

   localparam int MASK_W      = 8;
   localparam int PIN_W       = 8;
   localparam int SEL_W       = 3;
   localparam int FREQ_W      = 10;
   localparam int DUTY_W      = 8;
   localparam int DUTY_SAT_W  = 7;
   localparam int COUNT_W     = 32;
   localparam int PHASE_W     = 10;
   localparam int PERIOD_W    = 10;
   localparam int HUND_W      = 4;
   localparam int PROD_W      = HUND_W + DUTY_SAT_W;
   localparam int DIV_STEPS   = PERIOD_W;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
   localparam int DIV100_MUL  = 41;
   localparam int DIV100_SHR  = 12;
   localparam int DIV100_W    = PERIOD_W + 6;

   localparam int MS_PER_SECOND = 1000;
   localparam int PERCENT_FULL  = 100;
   localparam logic [COUNT_W-1:0] FOREVER_COUNT = 32'hffff_ffff;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLED_MASK = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACTIVE_LEVEL = 1'd1;

   localparam logic KIND_TICK = 1'b0;
   localparam logic KIND_MODE = 1'b1;

   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   typedef enum logic [1:0] {
      STATUS_OK,
      STATUS_DISABLED,
      STATUS_ZERO_FREQ,
      STATUS_FREQ_HIGH
   } status_type;

   typedef enum logic [1:0] {
      OP_TICK,
      OP_REJECT,
      OP_SINGLE,
      OP_BLINK
   } op_code_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_DIV,
      ST_SCALE,
      ST_MULT,
      ST_LOAD,
      ST_DONE
   } state_type;

   typedef struct packed {
      op_code_type             op_code;
      logic [SEL_W-1:0]        led_index;
      logic [FREQ_W-1:0]       frequency;
      logic [DUTY_SAT_W-1:0]   duty;
      logic [COUNT_W-1:0]      count;
      status_type              status;
   } op_type;

   // floor(p / 100) for p up to 1000
   function automatic logic [HUND_W-1:0] div100(input logic [PERIOD_W-1:0] p);
      logic [DIV100_W-1:0] prod;
      prod = DIV100_W'(p) * DIV100_W'(DIV100_MUL);
      return prod[DIV100_SHR +: HUND_W];
   endfunction

endpackage

// ===== design/lbc_front.sv =====
// ----------------------------------------------------------------------------
// lbc_front
// Accepts request transactions, checks commands and classifies them for the
// execution side.
// ----------------------------------------------------------------------------
module lbc_front (
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_kind,
   input  logic [lbc_pkg::SEL_W-1:0]     req_led_index,
   input  logic [lbc_pkg::FREQ_W-1:0]    req_frequency,
   input  logic [lbc_pkg::DUTY_W-1:0]    req_duty,
   input  logic [lbc_pkg::COUNT_W-1:0]   req_count,
   input  logic [lbc_pkg::MASK_W-1:0]    enabled_mask,
   output logic                          push_valid,
   input  logic                          push_ready,
   output lbc_pkg::op_type               push_op
);
   import lbc_pkg::*;

   logic                  led_ok;
   logic                  freq_zero;
   logic                  count_zero;
   logic [DUTY_SAT_W-1:0] duty_sat;
   status_type            cmd_status;

   assign req_ready  = push_ready;
   assign push_valid = req_valid;

   assign led_ok     = (32'(req_led_index) < NUM_LEDS) && enabled_mask[req_led_index];
   assign freq_zero  = (req_frequency == '0);
   assign count_zero = (req_count == '0);
   assign duty_sat   = (req_duty > DUTY_W'(PERCENT_FULL)) ? DUTY_SAT_W'(PERCENT_FULL)
                                                         : req_duty[DUTY_SAT_W-1:0];

   always_comb begin
      if (!led_ok) begin
         cmd_status = STATUS_DISABLED;
      end else if (freq_zero && !count_zero) begin
         cmd_status = STATUS_ZERO_FREQ;
      end else if (req_frequency > FREQ_W'(MS_PER_SECOND)) begin
         cmd_status = STATUS_FREQ_HIGH;
      end else begin
         cmd_status = STATUS_OK;
      end
   end

   always_comb begin
      push_op.led_index = req_led_index;
      push_op.frequency = req_frequency;
      push_op.duty      = duty_sat;
      push_op.count     = req_count;
      if (req_kind == KIND_TICK) begin
         push_op.op_code = OP_TICK;
         push_op.status  = STATUS_OK;
      end else if (cmd_status != STATUS_OK) begin
         push_op.op_code = OP_REJECT;
         push_op.status  = cmd_status;
      end else if (count_zero) begin
         push_op.op_code = OP_SINGLE;
         push_op.status  = STATUS_OK;
      end else begin
         push_op.op_code = OP_BLINK;
         push_op.status  = STATUS_OK;
      end
   end

endmodule

// ===== design/lbc_fifo.sv =====
// ----------------------------------------------------------------------------
// lbc_fifo
// Short queue of classified operations between front and execution side.
// ----------------------------------------------------------------------------
module lbc_fifo (
   input  logic            clock,
   input  logic            reset,
   input  logic            push_valid,
   output logic            push_ready,
   input  lbc_pkg::op_type push_op,
   output logic            pop_valid,
   input  logic            pop_ready,
   output lbc_pkg::op_type pop_op
);
   import lbc_pkg::*;

   op_type                entry_ff [FIFO_DEPTH];
   op_type                entry_in [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0] count_ff, count_in;
   logic                  do_push;
   logic                  do_pop;

   assign push_ready = (count_ff != FIFO_CNT_W'(FIFO_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_op     = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      entry_in  = entry_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         entry_in[wr_ptr_ff] = push_op;
         wr_ptr_in = (wr_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== design/lbc_exec.sv =====
// ----------------------------------------------------------------------------
// lbc_exec
// Execution side: per-LED blink state, tick walk, period divider, control
// registers and the response register.
// ----------------------------------------------------------------------------
module lbc_exec (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             op_valid,
   output logic                             op_ready,
   input  lbc_pkg::op_type                  op_data,
   input  logic                             csr_write_en,
   input  logic [lbc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [lbc_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output logic [lbc_pkg::MASK_W-1:0]       enabled_mask,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [lbc_pkg::PIN_W-1:0]        rsp_pin_levels,
   output lbc_pkg::status_type              rsp_status
);
   import lbc_pkg::*;

   state_type state_ff, state_in;

   op_type                op_ff, op_in;
   logic [LED_IDX_W-1:0]  walk_idx_ff, walk_idx_in;
   logic [FREQ_W:0]       rem_ff, rem_in;
   logic [PERIOD_W-1:0]   quo_ff, quo_in;
   logic [DIV_CNT_W-1:0]  div_cnt_ff, div_cnt_in;
   logic [HUND_W-1:0]     hund_ff, hund_in;
   logic [PHASE_W-1:0]    on_calc_ff, on_calc_in;

   logic [NUM_LEDS-1:0]   lit_ff, lit_in;
   logic [NUM_LEDS-1:0]   running_ff, running_in;
   logic [NUM_LEDS-1:0]   in_on_ff, in_on_in;
   logic [PHASE_W-1:0]    phase_ff [NUM_LEDS];
   logic [PHASE_W-1:0]    phase_in [NUM_LEDS];
   logic [PHASE_W-1:0]    on_time_ff [NUM_LEDS];
   logic [PHASE_W-1:0]    on_time_in [NUM_LEDS];
   logic [PHASE_W-1:0]    off_time_ff [NUM_LEDS];
   logic [PHASE_W-1:0]    off_time_in [NUM_LEDS];
   logic [COUNT_W-1:0]    cycles_ff [NUM_LEDS];
   logic [COUNT_W-1:0]    cycles_in [NUM_LEDS];

   logic [MASK_W-1:0]     enabled_ff, enabled_in;
   logic [MASK_W-1:0]     active_ff, active_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [PIN_W-1:0]      rsp_pins_ff, rsp_pins_in;
   status_type            rsp_status_ff, rsp_status_in;

   // control strobes from the sequencer
   logic pop_ok, pop, walk_step, div_step, scale_en, mult_en, load_en, done_en;
   logic walk_last, div_last;

   // selected LED
   logic [LED_IDX_W-1:0]  cur_idx;
   logic                  cur_lit, cur_run, cur_in_on;
   logic [PHASE_W-1:0]    cur_phase, cur_on, cur_off;
   logic [COUNT_W-1:0]    cur_cycles;
   logic [PHASE_W-1:0]    ph_dec;
   logic [COUNT_W-1:0]    cyc_dec;
   logic                  nxt_lit, nxt_run, nxt_in_on;
   logic [PHASE_W-1:0]    nxt_phase, nxt_on, nxt_off;
   logic [COUNT_W-1:0]    nxt_cycles;
   logic                  wr_en;

   logic [FREQ_W:0]       rem_shift;
   logic                  rem_ge;
   logic [PROD_W-1:0]     on_prod;
   logic [PHASE_W-1:0]    blink_off;

   logic [NUM_LEDS+MASK_W-1:0] en_old_pad, en_new_pad;
   logic [NUM_LEDS-1:0]        en_old, en_new, stop_mask;
   logic                       en_write;
   logic [NUM_LEDS+PIN_W-1:0]  lit_pad, led_pad;
   logic [PIN_W-1:0]           pins_now;

   assign pop_ok    = op_valid && (!rsp_valid_ff || rsp_ready);
   assign walk_last = (walk_idx_ff == LED_IDX_W'(NUM_LEDS - 1));
   assign div_last  = (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1));

   // ---------------- sequencer ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop_ok) begin
               unique case (op_data.op_code)
                  OP_TICK:   state_in = ST_WALK;
                  OP_REJECT: state_in = ST_DONE;
                  OP_SINGLE: state_in = ST_LOAD;
                  OP_BLINK:  state_in = ST_DIV;
                  default:   state_in = ST_DONE;
               endcase
            end
         end
         ST_WALK:  if (walk_last) state_in = ST_DONE;
         ST_DIV:   if (div_last) state_in = ST_SCALE;
         ST_SCALE: state_in = ST_MULT;
         ST_MULT:  state_in = ST_LOAD;
         ST_LOAD:  state_in = ST_DONE;
         ST_DONE:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      pop       = 1'b0;
      walk_step = 1'b0;
      div_step  = 1'b0;
      scale_en  = 1'b0;
      mult_en   = 1'b0;
      load_en   = 1'b0;
      done_en   = 1'b0;
      unique case (state_ff)
         ST_IDLE:  pop       = pop_ok;
         ST_WALK:  walk_step = 1'b1;
         ST_DIV:   div_step  = 1'b1;
         ST_SCALE: scale_en  = 1'b1;
         ST_MULT:  mult_en   = 1'b1;
         ST_LOAD:  load_en   = 1'b1;
         ST_DONE:  done_en   = 1'b1;
         default:  pop       = 1'b0;
      endcase
   end

   assign op_ready = pop;

   // ---------------- period divider and on-time scaling ----------------
   assign rem_shift = {rem_ff[FREQ_W-1:0], quo_ff[PERIOD_W-1]};
   assign rem_ge    = (rem_shift >= {1'b0, op_ff.frequency});
   assign on_prod   = PROD_W'(hund_ff) * PROD_W'(op_ff.duty);
   assign blink_off = quo_ff - on_calc_ff;

   always_comb begin
      op_in       = op_ff;
      walk_idx_in = walk_idx_ff;
      rem_in      = rem_ff;
      quo_in      = quo_ff;
      div_cnt_in  = div_cnt_ff;
      hund_in     = hund_ff;
      on_calc_in  = on_calc_ff;
      if (pop) begin
         op_in       = op_data;
         walk_idx_in = '0;
         rem_in      = '0;
         quo_in      = PERIOD_W'(MS_PER_SECOND);
         div_cnt_in  = '0;
      end
      if (walk_step) begin
         walk_idx_in = walk_idx_ff + 1'b1;
      end
      if (div_step) begin
         rem_in     = rem_ge ? (rem_shift - {1'b0, op_ff.frequency}) : rem_shift;
         quo_in     = {quo_ff[PERIOD_W-2:0], rem_ge};
         div_cnt_in = div_cnt_ff + 1'b1;
      end
      if (scale_en) begin
         hund_in = div100(quo_ff);
      end
      if (mult_en) begin
         on_calc_in = on_prod[PHASE_W-1:0];
      end
   end

   // ---------------- per-LED update ----------------
   assign cur_idx    = walk_step ? walk_idx_ff : LED_IDX_W'(op_ff.led_index);
   assign cur_lit    = lit_ff[cur_idx];
   assign cur_run    = running_ff[cur_idx];
   assign cur_in_on  = in_on_ff[cur_idx];
   assign cur_phase  = phase_ff[cur_idx];
   assign cur_on     = on_time_ff[cur_idx];
   assign cur_off    = off_time_ff[cur_idx];
   assign cur_cycles = cycles_ff[cur_idx];

   assign ph_dec  = cur_phase - PHASE_W'(cur_phase != '0);
   assign cyc_dec = (cur_cycles == FOREVER_COUNT) ? cur_cycles
                                                  : cur_cycles - COUNT_W'(cur_cycles != '0);
   assign wr_en   = walk_step || load_en;

   always_comb begin
      nxt_lit    = cur_lit;
      nxt_run    = cur_run;
      nxt_in_on  = cur_in_on;
      nxt_phase  = cur_phase;
      nxt_on     = cur_on;
      nxt_off    = cur_off;
      nxt_cycles = cur_cycles;
      if (walk_step) begin
         if (cur_run) begin
            if (ph_dec != '0) begin
               nxt_phase = ph_dec;
            end else if (cur_in_on && (cur_off != '0)) begin
               nxt_lit   = 1'b0;
               nxt_in_on = 1'b0;
               nxt_phase = cur_off;
            end else begin
               // end of a cycle
               nxt_cycles = cyc_dec;
               if (cyc_dec == '0) begin
                  nxt_run   = 1'b0;
                  nxt_in_on = 1'b0;
                  nxt_lit   = 1'b0;
                  nxt_phase = '0;
               end else if (cur_on != '0) begin
                  nxt_lit   = 1'b1;
                  nxt_in_on = 1'b1;
                  nxt_phase = cur_on;
               end else begin
                  nxt_lit   = 1'b0;
                  nxt_in_on = 1'b0;
                  nxt_phase = cur_off;
               end
            end
         end
      end else if (load_en) begin
         nxt_run   = 1'b0;
         nxt_in_on = 1'b0;
         nxt_phase = '0;
         if (op_ff.op_code == OP_SINGLE) begin
            nxt_lit = (op_ff.frequency == '0) ? !cur_lit : (op_ff.duty != '0);
         end else begin
            nxt_on     = on_calc_ff;
            nxt_off    = blink_off;
            nxt_cycles = op_ff.count;
            nxt_run    = 1'b1;
            if (on_calc_ff != '0) begin
               nxt_lit   = 1'b1;
               nxt_in_on = 1'b1;
               nxt_phase = on_calc_ff;
            end else begin
               nxt_lit   = 1'b0;
               nxt_in_on = 1'b0;
               nxt_phase = blink_off;
            end
         end
      end
   end

   // ---------------- enable changes ----------------
   assign en_write   = csr_write_en && (csr_index == CSR_ENABLED_MASK);
   assign en_old_pad = {{NUM_LEDS{1'b0}}, enabled_ff};
   assign en_new_pad = {{NUM_LEDS{1'b0}}, csr_wdata};
   assign en_old     = en_old_pad[NUM_LEDS-1:0];
   assign en_new     = en_new_pad[NUM_LEDS-1:0];
   assign stop_mask  = (~en_old & en_new) | (en_old & ~en_new & running_ff);

   always_comb begin
      lit_in      = lit_ff;
      running_in  = running_ff;
      in_on_in    = in_on_ff;
      phase_in    = phase_ff;
      on_time_in  = on_time_ff;
      off_time_in = off_time_ff;
      cycles_in   = cycles_ff;
      if (wr_en) begin
         lit_in[cur_idx]      = nxt_lit;
         running_in[cur_idx]  = nxt_run;
         in_on_in[cur_idx]    = nxt_in_on;
         phase_in[cur_idx]    = nxt_phase;
         on_time_in[cur_idx]  = nxt_on;
         off_time_in[cur_idx] = nxt_off;
         cycles_in[cur_idx]   = nxt_cycles;
      end
      if (en_write) begin
         lit_in     = lit_in & ~stop_mask;
         running_in = running_in & ~stop_mask;
         in_on_in   = in_on_in & ~stop_mask;
      end
   end

   always_comb begin
      enabled_in = enabled_ff;
      active_in  = active_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_ENABLED_MASK: enabled_in = csr_wdata;
            CSR_ACTIVE_LEVEL: active_in  = csr_wdata;
            default:          enabled_in = enabled_ff;
         endcase
      end
   end

   assign enabled_mask = enabled_ff;

   // ---------------- response register ----------------
   assign lit_pad  = {{PIN_W{1'b0}}, lit_ff};
   assign led_pad  = {{PIN_W{1'b0}}, {NUM_LEDS{1'b1}}};
   assign pins_now = ~(lit_pad[PIN_W-1:0] ^ active_ff) & led_pad[PIN_W-1:0];

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_pins_in   = rsp_pins_ff;
      rsp_status_in = rsp_status_ff;
      if (done_en) begin
         rsp_valid_in  = 1'b1;
         rsp_pins_in   = pins_now;
         rsp_status_in = op_ff.status;
      end else if (rsp_ready) begin
         rsp_valid_in  = 1'b0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pin_levels = rsp_pins_ff;
   assign rsp_status     = rsp_status_ff;

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         lit_ff       <= '0;
         running_ff   <= '0;
         in_on_ff     <= '0;
         enabled_ff   <= '0;
         active_ff    <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lit_ff       <= lit_in;
         running_ff   <= running_in;
         in_on_ff     <= in_on_in;
         enabled_ff   <= enabled_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      walk_idx_ff   <= walk_idx_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      div_cnt_ff    <= div_cnt_in;
      hund_ff       <= hund_in;
      on_calc_ff    <= on_calc_in;
      phase_ff      <= phase_in;
      on_time_ff    <= on_time_in;
      off_time_ff   <= off_time_in;
      cycles_ff     <= cycles_in;
      rsp_pins_ff   <= rsp_pins_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule

// ===== design/led_blink_controller.sv =====
// ----------------------------------------------------------------------------
// led_blink_controller
// Multi-LED blink controller driven by tick and mode command transactions.
//
// Request channel (req_*): one transaction per item, either a 1 ms tick
// (req_kind 0) or a mode command for one LED (req_kind 1). Every request
// produces exactly one response transaction (rsp_*) carrying the pin levels
// of all LEDs after the item and a status code.
// Control registers are written through csr_write_en/csr_index/csr_wdata:
// index 0 is the enable mask, index 1 the active level mask. Write them
// only while no transaction is in flight.
// From request accept to rsp_valid: a tick walks the LEDs (one LED updated
// per cycle); a blink command runs the one-bit-per-cycle period divider,
// then scaling, multiply and load; a single-action command loads directly
// and a rejected command goes straight to the response. The execution side
// takes a new item only once it is idle and the response register is free.
// A two-entry queue lets requests be accepted while a response waits; if the
// receiver stalls, the queue fills and req_ready drops.
// Reset clears all LEDs to dark and idle, the enable mask to zero and the
// active level mask to all ones.
// ----------------------------------------------------------------------------
module led_blink_controller (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_kind,
   input  logic [lbc_pkg::SEL_W-1:0]        req_led_index,
   input  logic [lbc_pkg::FREQ_W-1:0]       req_frequency,
   input  logic [lbc_pkg::DUTY_W-1:0]       req_duty,
   input  logic [lbc_pkg::COUNT_W-1:0]      req_count,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [lbc_pkg::PIN_W-1:0]        rsp_pin_levels,
   output logic [1:0]                       rsp_status,
   input  logic                             csr_write_en,
   input  logic [lbc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [lbc_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import lbc_pkg::*;

   logic              push_valid;
   logic              push_ready;
   op_type            push_op;
   logic              pop_valid;
   logic              pop_ready;
   op_type            pop_op;
   logic [MASK_W-1:0] enabled_mask;
   status_type        status;

   lbc_front u_front (
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_kind      (req_kind),
      .req_led_index (req_led_index),
      .req_frequency (req_frequency),
      .req_duty      (req_duty),
      .req_count     (req_count),
      .enabled_mask  (enabled_mask),
      .push_valid    (push_valid),
      .push_ready    (push_ready),
      .push_op       (push_op)
   );

   lbc_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_op    (push_op),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_op     (pop_op)
   );

   lbc_exec u_exec (
      .clock          (clock),
      .reset          (reset),
      .op_valid       (pop_valid),
      .op_ready       (pop_ready),
      .op_data        (pop_op),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .enabled_mask   (enabled_mask),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pin_levels (rsp_pin_levels),
      .rsp_status     (status)
   );

   assign rsp_status = status;

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the LED blink controller.
//
// Tick and mode command transactions are queued by a stimulus process and
// fed to the request channel by a clocked driver. A clocked monitor predicts
// the pin levels and status of every accepted transaction with a local copy
// of the per-LED blink state and checks each response in order. A short
// directed sequence comes first, then random phases under different enable
// and polarity settings and different sender and receiver idling.
// ----------------------------------------------------------------------------
module tb_top;
   import lbc_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int REPORT_MAX  = 10;
   localparam int PHASE_ITEMS = 137;

   typedef struct {
      logic                 kind;
      logic [SEL_W-1:0]     led_index;
      logic [FREQ_W-1:0]    frequency;
      logic [DUTY_W-1:0]    duty;
      logic [COUNT_W-1:0]   count;
   } led_req_type;

   typedef struct {
      logic [PIN_W-1:0] pins;
      status_type       status;
   } led_rsp_type;

   typedef enum int {
      PH_ENTER_ON,
      PH_ENTER_OFF,
      PH_END_CYCLE
   } led_phase_step_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic                    req_kind = KIND_TICK;
   logic [SEL_W-1:0]        req_led_index = '0;
   logic [FREQ_W-1:0]       req_frequency = '0;
   logic [DUTY_W-1:0]       req_duty = '0;
   logic [COUNT_W-1:0]      req_count = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [PIN_W-1:0]        rsp_pin_levels;
   logic [1:0]              rsp_status;
   logic                    csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0]  csr_index = CSR_ENABLED_MASK;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;

   led_blink_controller u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_led_index  (req_led_index),
      .req_frequency  (req_frequency),
      .req_duty       (req_duty),
      .req_count      (req_count),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pin_levels (rsp_pin_levels),
      .rsp_status     (rsp_status),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- blink state
   logic [MASK_W-1:0]   led_enabled = '0;
   logic [MASK_W-1:0]   led_active = '1;
   logic                led_lit [NUM_LEDS];
   logic                led_running [NUM_LEDS];
   logic                led_on_phase [NUM_LEDS];
   logic [PHASE_W-1:0]  led_phase_left [NUM_LEDS];
   logic [PHASE_W-1:0]  led_on_ms [NUM_LEDS];
   logic [PHASE_W-1:0]  led_off_ms [NUM_LEDS];
   logic [COUNT_W-1:0]  led_cycles_left [NUM_LEDS];

   led_req_type  pending_items [$];
   led_rsp_type  expected_rsps [$];
   int        send_idle_pct = 0;
   int        recv_stall_pct = 0;
   int        error_count = 0;
   int        n_items = 0;
   int        n_ticks = 0;
   int        n_rejects = 0;
   int        n_blinks = 0;
   int        n_blink_ends = 0;
   int        cycle_count = 0;

   initial begin
      for (int i = 0; i < NUM_LEDS; i++) begin
         led_lit[i] = 1'b0;
         led_running[i] = 1'b0;
         led_on_phase[i] = 1'b0;
         led_phase_left[i] = '0;
         led_on_ms[i] = '0;
         led_off_ms[i] = '0;
         led_cycles_left[i] = '0;
      end
   end

   function automatic void led_stop_dark(input int i);
      led_running[i] = 1'b0;
      led_on_phase[i] = 1'b0;
      led_phase_left[i] = '0;
      led_lit[i] = 1'b0;
   endfunction

   // Walks zero-length phases until one with time left, or the blink ends.
   function automatic void led_advance(input int i, input led_phase_step_type first_step);
      led_phase_step_type step;
      int                 guard;
      step = first_step;
      for (guard = 0; guard < 6; guard++) begin
         case (step)
            PH_ENTER_ON: begin
               if (led_on_ms[i] != 0) begin
                  led_lit[i] = 1'b1;
                  led_on_phase[i] = 1'b1;
                  led_phase_left[i] = led_on_ms[i];
                  return;
               end
               step = PH_ENTER_OFF;
            end
            PH_ENTER_OFF: begin
               if (led_off_ms[i] != 0) begin
                  led_lit[i] = 1'b0;
                  led_on_phase[i] = 1'b0;
                  led_phase_left[i] = led_off_ms[i];
                  return;
               end
               step = PH_END_CYCLE;
            end
            default: begin
               if (led_cycles_left[i] != FOREVER_COUNT) begin
                  if (led_cycles_left[i] != 0) led_cycles_left[i]--;
                  if (led_cycles_left[i] == 0) begin
                     led_stop_dark(i);
                     n_blink_ends++;
                     return;
                  end
               end
               step = PH_ENTER_ON;
            end
         endcase
      end
   endfunction

   function automatic void apply_csr(input logic [CSR_INDEX_W-1:0] idx,
                                     input logic [CSR_DATA_W-1:0] data);
      int i;
      if (idx == CSR_ENABLED_MASK) begin
         for (i = 0; i < NUM_LEDS; i++) begin
            if (!led_enabled[i] && data[i])
               led_stop_dark(i);
            else if (led_enabled[i] && !data[i] && led_running[i])
               led_stop_dark(i);
         end
         led_enabled = data;
      end else begin
         led_active = data;
      end
   endfunction

   function automatic led_rsp_type predict_pins(input led_req_type it);
      led_rsp_type  r;
      int        i;
      int        idx;
      int        duty_sat;
      int        period_ms;
      int        on_ms;
      r.status = STATUS_OK;
      if (it.kind == KIND_TICK) begin
         n_ticks++;
         for (i = 0; i < NUM_LEDS; i++) begin
            if (led_running[i]) begin
               if (led_phase_left[i] != 0) led_phase_left[i]--;
               if (led_phase_left[i] == 0)
                  led_advance(i, led_on_phase[i] ? PH_ENTER_OFF : PH_END_CYCLE);
            end
         end
      end else begin
         idx = int'(it.led_index);
         duty_sat = (it.duty > PERCENT_FULL) ? PERCENT_FULL : int'(it.duty);
         if (idx >= NUM_LEDS || !led_enabled[idx])
            r.status = STATUS_DISABLED;
         else if (it.frequency == 0 && it.count != 0)
            r.status = STATUS_ZERO_FREQ;
         else if (it.frequency > MS_PER_SECOND)
            r.status = STATUS_FREQ_HIGH;
         else begin
            led_running[idx] = 1'b0;
            led_on_phase[idx] = 1'b0;
            led_phase_left[idx] = '0;
            if (it.count == 0) begin
               if (it.frequency == 0)
                  led_lit[idx] = ~led_lit[idx];
               else
                  led_lit[idx] = (duty_sat != 0);
            end else begin
               period_ms = MS_PER_SECOND / int'(it.frequency);
               on_ms = (period_ms / PERCENT_FULL) * duty_sat;
               led_on_ms[idx] = PHASE_W'(on_ms);
               led_off_ms[idx] = PHASE_W'(period_ms - on_ms);
               led_cycles_left[idx] = it.count;
               led_running[idx] = 1'b1;
               n_blinks++;
               led_advance(idx, PH_ENTER_ON);
            end
         end
         if (r.status != STATUS_OK) n_rejects++;
      end
      for (i = 0; i < PIN_W; i++)
         r.pins[i] = (i < NUM_LEDS) ? (led_lit[i] ? led_active[i] : ~led_active[i]) : 1'b0;
      return r;
   endfunction

   // ---------------------------------------------------------------- driver
   led_req_type next_item;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_item = pending_items.pop_front();
            req_valid <= 1'b1;
            req_kind <= next_item.kind;
            req_led_index <= next_item.led_index;
            req_frequency <= next_item.frequency;
            req_duty <= next_item.duty;
            req_count <= next_item.count;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // ---------------------------------------------------------------- monitor
   led_req_type seen_item;
   led_rsp_type want;

   task automatic report_error(input string msg);
      error_count++;
      if (error_count <= REPORT_MAX) $display("ERROR: %s", msg);
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            seen_item.kind = req_kind;
            seen_item.led_index = req_led_index;
            seen_item.frequency = req_frequency;
            seen_item.duty = req_duty;
            seen_item.count = req_count;
            expected_rsps.push_back(predict_pins(seen_item));
            n_items++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               report_error($sformatf("unexpected response pins %02h status %0d",
                                      rsp_pin_levels, rsp_status));
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_pin_levels !== want.pins || rsp_status !== want.status)
                  report_error($sformatf(
                     "response %0d: pins exp %02h got %02h, status exp %0d got %0d",
                     n_items - expected_rsps.size() - 1, want.pins, rsp_pin_levels,
                     want.status, rsp_status));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, expected_rsps.size());
         $display("tb_top NOT OK");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus
   function automatic led_req_type make_cmd(input int idx, input int freq, input int duty,
                                            input logic [COUNT_W-1:0] cnt);
      led_req_type it;
      it.kind = KIND_MODE;
      it.led_index = SEL_W'(idx);
      it.frequency = FREQ_W'(freq);
      it.duty = DUTY_W'(duty);
      it.count = cnt;
      return it;
   endfunction

   function automatic led_req_type make_tick();
      led_req_type it;
      it.kind = KIND_TICK;
      it.led_index = SEL_W'($urandom);
      it.frequency = FREQ_W'($urandom);
      it.duty = DUTY_W'($urandom);
      it.count = COUNT_W'($urandom);
      return it;
   endfunction

   function automatic led_req_type random_item();
      led_req_type it;
      int          sel;
      it = make_tick();
      sel = $urandom_range(99);
      if (sel < 5) begin
         it.kind = 1'($urandom_range(1));
         return it;
      end
      if (sel < 66) return it;
      it.kind = KIND_MODE;
      sel = $urandom_range(99);
      if (sel < 40)      it.frequency = FREQ_W'($urandom_range(MS_PER_SECOND, 100));
      else if (sel < 70) it.frequency = FREQ_W'($urandom_range(10, 5));
      else if (sel < 80) it.frequency = '0;
      else if (sel < 90) it.frequency = FREQ_W'($urandom_range(1023, MS_PER_SECOND + 1));
      sel = $urandom_range(99);
      if (sel < 40)      it.duty = DUTY_W'($urandom_range(10));
      else if (sel < 70) it.duty = DUTY_W'($urandom_range(PERCENT_FULL, 90));
      sel = $urandom_range(99);
      if (sel < 35)      it.count = '0;
      else if (sel < 80) it.count = COUNT_W'($urandom_range(3, 1));
      else if (sel < 90) it.count = FOREVER_COUNT;
      return it;
   endfunction

   // sampled on the falling edge so the driver's updates have settled
   task automatic wait_idle();
      while (pending_items.size() != 0 || req_valid || expected_rsps.size() != 0)
         @(negedge clock);
      repeat (NUM_LEDS + 3) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      apply_csr(idx, data);
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic run_phase(input logic [MASK_W-1:0] en, input logic [MASK_W-1:0] act,
                            input int send_pct, input int stall_pct);
      wait_idle();
      write_csr(CSR_ENABLED_MASK, en);
      write_csr(CSR_ACTIVE_LEVEL, act);
      send_idle_pct = send_pct;
      recv_stall_pct = stall_pct;
      for (int k = 0; k < PHASE_ITEMS; k++) pending_items.push_back(random_item());
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset state: everything dark and disabled
      write_csr(CSR_ENABLED_MASK, 8'h00);
      write_csr(CSR_ACTIVE_LEVEL, 8'hff);
      pending_items.push_back(make_tick());
      pending_items.push_back(make_cmd(3, 10, 50, 5));
      wait_idle();

      write_csr(CSR_ENABLED_MASK, 8'hff);
      write_csr(CSR_ACTIVE_LEVEL, 8'h5a);
      pending_items.push_back(make_cmd(0, 0, 0, 0));
      pending_items.push_back(make_cmd(0, 0, 77, 0));
      pending_items.push_back(make_cmd(1, 5, 0, 0));
      pending_items.push_back(make_cmd(1, 1000, 255, 0));
      pending_items.push_back(make_cmd(2, 0, 40, 7));
      pending_items.push_back(make_cmd(2, 1001, 40, 0));
      pending_items.push_back(make_cmd(2, 1023, 40, 3));
      pending_items.push_back(make_cmd(3, 1000, 50, 2));
      pending_items.push_back(make_cmd(4, 10, 100, 2));
      pending_items.push_back(make_cmd(5, 1, 100, 1));
      pending_items.push_back(make_cmd(6, 100, 30, FOREVER_COUNT));
      pending_items.push_back(make_cmd(7, 9, 1, 3));
      pending_items.push_back(make_cmd(5, 50, 60, 0));
      pending_items.push_back(make_cmd(3, 1, 0, 1));
      repeat (10) pending_items.push_back(make_tick());
      pending_items.push_back(make_cmd(6, 0, 0, 0));

      run_phase(8'hff, 8'h00, 0, 0);
      run_phase(8'h5a, 8'hff, 45, 0);
      run_phase(8'hff, 8'ha5, 0, 45);
      run_phase(8'h3c, 8'h00, 29, 29);
      wait_idle();
      repeat (20) @(posedge clock);

      $display("Covered %0d transactions: %0d ticks, %0d commands (%0d rejected, %0d blinks",
               n_items, n_ticks, n_items - n_ticks, n_rejects, n_blinks);
      $display("started, %0d ran to completion) over six register settings; %0d errors",
               n_blink_ends, error_count);
      if (error_count == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
